@@ hdl/ils_pkg.sv @@
package ils_pkg;

  // list geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);

  // field widths
  localparam int REQ_W = 3;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HEAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TAIL   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_AT     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

endpackage

@@ hdl/ils_ram.sv @@
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/indexed_list_store.sv @@
// Ordered list of up to MAX_ENTRIES signed 32-bit values held in one simple
// dual-port RAM (one write, one registered read per cycle) with an entry count
// in flip-flops. Each request transfer yields exactly one result transfer.
// The next request can be taken on the first edge at which the result can
// transfer. A read goes through the RAM's registered read port. An insert at
// position p moves the count-p entries at and above it one place up, one entry
// per cycle through the RAM's single read and write ports, and then writes the
// new value; an append moves nothing. A delete at position p moves count-p-1
// entries down, so none for the last entry. Rejected requests (bad position,
// full list, unknown type) go straight to the done state.
// A stalled output holds a finished result in its register; the next request
// is taken meanwhile and waits in its final state until the register frees.
// Reset clears the state, the count, the cursor and the output valid only; RAM
// contents are never read beyond the count, so the RAM needs no clearing pass.
module indexed_list_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ils_pkg::REQ_W-1:0]  req_type,
  input  logic [ils_pkg::POS_W-1:0]  position,
  input  logic signed [ils_pkg::VAL_W-1:0] value_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [ils_pkg::VAL_W-1:0] read_value,
  output logic [ils_pkg::ST_W-1:0]   status,
  output logic [ils_pkg::CNT_W-1:0]  list_length
);

  import ils_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDWAIT = 6'b000010,
    S_INS    = 6'b000100,
    S_DEL    = 6'b001000,
    S_PUT    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] cur, cur_next;

  // per-request payload, held for the length of the request
  logic [CNT_W-1:0] slot, slot_next;
  logic [VAL_W-1:0] val, val_next;
  logic [VAL_W-1:0] res_value, res_value_next;
  logic [ST_W-1:0]  res_status, res_status_next;

  // RAM ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] ins_slot;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Slot an insert lands in: head, tail or the requested position.
  always_comb begin
    case (req_type)
      REQ_HEAD: ins_slot = '0;
      REQ_TAIL: ins_slot = count;
      default:  ins_slot = position;
    endcase
  end

  // Reads run one slot ahead of writes, so the shift loop never writes an
  // entry it has still to read: insert walks down, delete walks up.
  always_comb begin
    state_next      = state;
    count_next      = count;
    cur_next        = cur;
    slot_next       = slot;
    val_next        = val;
    res_value_next  = res_value;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = cur;

    case (state)
      S_IDLE: begin
        if (accept) begin
          val_next        = value_in;
          res_value_next  = '0;
          res_status_next = ST_DONE;
          state_next      = S_DONE;
          case (req_type)
            REQ_READ: begin
              if (position < count) begin
                rd_en      = 1'b1;
                rd_addr    = position[IDX_W-1:0];
                state_next = S_RDWAIT;
              end else begin
                res_value_next  = '1;
                res_status_next = ST_RANGE;
              end
            end
            REQ_HEAD, REQ_TAIL, REQ_AT: begin
              slot_next = ins_slot;
              if (ins_slot > count) begin
                res_status_next = ST_RANGE;
              end else if (count >= CNT_MAX) begin
                res_status_next = ST_FULL;
              end else if (ins_slot == count) begin
                // append: nothing to move
                state_next = S_PUT;
              end else begin
                cur_next   = IDX_W'(count - 1'b1);
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(count - 1'b1);
                state_next = S_INS;
              end
            end
            REQ_DELETE: begin
              if (position < count) begin
                if (CNT_W'(position + 1'b1) == count) begin
                  // last entry: drop it without moving anything
                  count_next = CNT_W'(count - 1'b1);
                end else begin
                  cur_next   = IDX_W'(position + 1'b1);
                  rd_en      = 1'b1;
                  rd_addr    = IDX_W'(position + 1'b1);
                  state_next = S_DEL;
                end
              end else begin
                res_status_next = ST_RANGE;
              end
            end
            default: begin
              res_status_next = ST_RANGE;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_value_next = rd_data;
        state_next     = S_DONE;
      end

      S_INS: begin
        // move entry cur up one place
        wr_en   = 1'b1;
        wr_addr = IDX_W'(cur + 1'b1);
        if (CNT_W'(cur) == slot) begin
          state_next = S_PUT;
        end else begin
          cur_next = IDX_W'(cur - 1'b1);
          rd_en    = 1'b1;
          rd_addr  = IDX_W'(cur - 1'b1);
        end
      end

      S_DEL: begin
        // move entry cur down one place
        wr_en   = 1'b1;
        wr_addr = IDX_W'(cur - 1'b1);
        if (CNT_W'(cur) == CNT_W'(count - 1'b1)) begin
          count_next = CNT_W'(count - 1'b1);
          state_next = S_DONE;
        end else begin
          cur_next = IDX_W'(cur + 1'b1);
          rd_en    = 1'b1;
          rd_addr  = IDX_W'(cur + 1'b1);
        end
      end

      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = slot[IDX_W-1:0];
        wr_data    = val;
        count_next = CNT_W'(count + 1'b1);
        state_next = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  ils_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cur   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      cur   <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    slot       <= slot_next;
    val        <= val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  // Output register: load on leaving S_DONE, drop valid on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      read_value  <= res_value;
      status      <= res_status;
      list_length <= count;
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count above capacity");

  // The count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |->
      (count == CNT_W'($past(count) + 1'b1) || count == CNT_W'($past(count) - 1'b1)))
    else $error("entry count jumped");

  // The RAM is written only while moving entries or placing a new one.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_INS || state == S_DEL || state == S_PUT))
    else $error("RAM write outside shift or put");

  // A full refusal is only reported with a full list.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> list_length == CNT_MAX)
    else $error("full status with room left");

endmodule

@@ bench/tb_indexed_list_store.sv @@
module tb_indexed_list_store;
  import ils_pkg::*;

  // Request codes above delete are not recognised by the block.
  localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_DELETE + 3'd1;
  localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = '1;
  localparam logic [POS_W-1:0] POS_TOP          = '1;

  localparam int RANDOM_PER_PHASE = 360;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int SETTLE_CYCLES    = 40;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        list_length;
  } list_result_t;

  // Tracks the list contents as each request transfer is accepted and
  // holds the results still owed by the block, oldest first.
  class list_tracker;
    logic signed [VAL_W-1:0] slots[MAX_ENTRIES];
    int                      count;
    list_result_t            owed_results[$];
    int                      errors;

    function new();
      count  = 0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function logic [ST_W-1:0] insert_at(int pos, logic signed [VAL_W-1:0] val);
      if (pos > count) return ST_RANGE;
      if (count >= MAX_ENTRIES) return ST_FULL;
      for (int k = count; k > pos; k--) slots[k] = slots[k-1];
      slots[pos] = val;
      count++;
      return ST_DONE;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      list_result_t r;
      r.read_value = '0;
      r.status     = ST_DONE;
      case (req)
        REQ_READ: begin
          if (int'(pos) < count) begin
            r.read_value = slots[pos];
          end else begin
            r.read_value = -1;
            r.status     = ST_RANGE;
          end
        end
        REQ_HEAD:   r.status = insert_at(0, val);
        REQ_TAIL:   r.status = insert_at(count, val);
        REQ_AT:     r.status = insert_at(int'(pos), val);
        REQ_DELETE: begin
          if (int'(pos) < count) begin
            for (int k = pos; k + 1 < count; k++) slots[k] = slots[k+1];
            count--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        default:    r.status = ST_RANGE;
      endcase
      r.list_length = CNT_W'(count);
      owed_results.push_back(r);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] rd, logic [ST_W-1:0] st,
                               logic [CNT_W-1:0] len);
      list_result_t want;
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing outstanding: read_value %0d status %0d",
               rd, st);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (rd !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, rd);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (len !== want.list_length) begin
        $error("list_length: expected %0d, got %0d", want.list_length, len);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void close();
      if (owed_results.size() != 0) begin
        $error("%0d results never arrived", owed_results.size());
        errors++;
      end
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic [REQ_W-1:0]        req_type    = REQ_READ;
  logic [POS_W-1:0]        position    = '0;
  logic signed [VAL_W-1:0] value_in    = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        list_length;

  list_tracker tracker = new();

  // Idle percentages for each side; the stimulus process changes them per phase.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Bias of the random part: fill towards full, or drain towards empty.
  bit growing = 1'b1;

  indexed_list_store u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .position   (position),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status),
    .list_length(list_length)
  );

  always #5 clk = ~clk;

  // Receiver: draw a fresh ready each cycle, stalling at the phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every result transfer against the oldest outstanding prediction.
  // Values are sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result(read_value, status, list_length);
  end

  // Present one request and hold it until the block takes it. Idle cycles
  // go in front of the request, so valid drops only between transfers.
  // The prediction is advanced here, at the accepting edge, so that the
  // random bias below always sees an up-to-date count.
  task automatic send_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                              logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    position <= pos;
    value_in <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(req, pos, val);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed positions within the list; now and then any 5-bit value.
  function automatic logic [POS_W-1:0] pick_position(int hi);
    if (hi < 0 || $urandom_range(4) == 0) return POS_W'($urandom_range(31));
    return POS_W'($urandom_range(hi));
  endfunction

  task automatic run_random(int items);
    int               n;
    int               draw;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    for (n = 0; n < items; n++) begin
      // Flip the bias rarely in mid-range and readily at either end.
      if ((tracker.count == MAX_ENTRIES && growing) || (tracker.count == 0 && !growing)) begin
        if ($urandom_range(7) == 0) growing = !growing;
      end else if ($urandom_range(59) == 0) begin
        growing = !growing;
      end
      draw = $urandom_range(99);
      if (draw < 5)
        req = REQ_W'($urandom_range(REQ_LAST_UNUSED, REQ_FIRST_UNUSED));
      else if (draw < 20)
        req = REQ_READ;
      else if (draw < 70)
        req = growing ? REQ_W'($urandom_range(REQ_AT, REQ_HEAD)) : REQ_DELETE;
      else
        req = growing ? REQ_DELETE : REQ_W'($urandom_range(REQ_AT, REQ_HEAD));
      if (req == REQ_AT)
        pos = pick_position(tracker.count);
      else
        pos = pick_position(tracker.count - 1);
      send_request(req, pos, pick_value());
    end
  endtask

  initial begin
    int drain_cycles;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty-list rejects and unknown codes first.
    send_request(REQ_READ, '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_AT, 5'd1, 32'sd7);
    send_request(REQ_FIRST_UNUSED, '0, 32'sd1);
    send_request(REQ_LAST_UNUSED, POS_TOP, -1);

    // Build up with every insert flavour, extremes of value included.
    send_request(REQ_HEAD, POS_TOP, 32'sh8000_0000);
    send_request(REQ_TAIL, '0, 32'sh7fff_ffff);
    send_request(REQ_AT, 5'd1, '0);
    send_request(REQ_AT, 5'd3, -1);
    send_request(REQ_READ, 5'd0, '0);
    send_request(REQ_READ, 5'd3, '0);
    send_request(REQ_AT, 5'd5, 32'sd3);
    while (tracker.count < MAX_ENTRIES)
      send_request(REQ_TAIL, '0, $urandom);

    // Full list: a bad position is reported ahead of the full condition.
    send_request(REQ_AT, 5'd17, 32'sd9);
    send_request(REQ_AT, 5'd16, 32'sd9);
    send_request(REQ_HEAD, '0, 32'sd9);
    send_request(REQ_READ, 5'd15, '0);
    send_request(REQ_READ, 5'd16, '0);
    send_request(REQ_READ, POS_TOP, '0);
    send_request(REQ_DELETE, 5'd16, '0);
    send_request(REQ_DELETE, 5'd15, '0);
    send_request(REQ_DELETE, 5'd0, '0);

    // Random part in three idling phases.
    tx_idle_pct = 31;
    rx_idle_pct = 76;
    run_random(RANDOM_PER_PHASE);
    tx_idle_pct = 76;
    rx_idle_pct = 31;
    run_random(RANDOM_PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);

    // Drop valid after the last transfer and let the results drain.
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (tracker.outstanding() > 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    // Allow for a worst-case shift before declaring nothing stray is left.
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.close();

    if (tracker.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ils_pkg.sv
hdl/ils_ram.sv
hdl/indexed_list_store.sv
bench/tb_indexed_list_store.sv
